>>> rtl/wcs_pkg.sv
// Shared types and constants of the whitespace and comment skipper.
// No dependencies; every other file uses these by scoped name.
package wcs_pkg;

    localparam int unsigned MAX_NEST   = 255;
    localparam longint unsigned MAX_LENGTH = 65535;

    localparam int unsigned CH_W     = 16;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned NEST_W   = $clog2(MAX_NEST + 1);
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 1;

    localparam logic [LEN_W-1:0] LEN_LIMIT =
        (MAX_LENGTH > 64'd65535) ? 16'hFFFF : LEN_W'(MAX_LENGTH);
    localparam logic [NEST_W-1:0] NEST_LIMIT = NEST_W'(MAX_NEST);

    localparam logic [CH_W-1:0] CH_TAB   = 16'h0009;
    localparam logic [CH_W-1:0] CH_LF    = 16'h000A;
    localparam logic [CH_W-1:0] CH_CR    = 16'h000D;
    localparam logic [CH_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CH_W-1:0] CH_STAR  = 16'h002A;
    localparam logic [CH_W-1:0] CH_SLASH = 16'h002F;
    localparam logic [CH_W-1:0] CH_BSL   = 16'h005C;
    localparam logic [CH_W-1:0] CH_IDSP  = 16'h3000;

    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_NEWLINES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_NONEMPTY = 1'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_UNCLOSED = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_TOP       = 9'b000000010,
        PH_SLASH     = 9'b000000100,
        PH_BSL       = 9'b000001000,
        PH_BSCR      = 9'b000010000,
        PH_LINE      = 9'b000100000,
        PH_BLK       = 9'b001000000,
        PH_BLK_SLASH = 9'b010000000,
        PH_BLK_STAR  = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            first;
        logic            end_of_input;
    } item_t;

    typedef struct packed {
        logic skip_newlines;
        logic require_nonempty;
    } cfg_t;

endpackage

>>> rtl/wcs_if.sv
// Valid/ready channel interfaces for characters and results.
// Depends on wcs_pkg for field widths.
interface wcs_char_if;
    logic                        valid;
    logic                        ready;
    logic [wcs_pkg::CH_W-1:0]    ch;
    logic                        first;
    logic                        end_of_input;

    modport source (output valid, ch, first, end_of_input, input ready);
    modport sink   (input valid, ch, first, end_of_input, output ready);
endinterface

interface wcs_result_if;
    logic                          valid;
    logic                          ready;
    logic [wcs_pkg::LEN_W-1:0]     run_length;
    logic [wcs_pkg::STATUS_W-1:0]  status;

    modport source (output valid, run_length, status, input ready);
    modport sink   (input valid, run_length, status, output ready);
endinterface

>>> rtl/whitespace_comment_skipper_core.sv
// Top level of the whitespace and comment skipper: config registers,
// input register and scan stage. Depends on wcs_pkg, wcs_if, wcs_in_stage, wcs_scan.
//
//   channel  | dir | payload                      | transfer
//   ---------+-----+------------------------------+-------------------
//   chars    | in  | ch[15:0], first, end_of_input | valid && ready
//   result   | out | run_length[15:0], status[1:0] | valid && ready
//   cfg      | in  | cfg_index, cfg_data           | cfg_we
//
// One character per cycle unless a held result stalls the input; the scan step is a single state update
// between the input register and the result register.
// rst_n clears the scan to idle and both configuration bits to 0.
// A held result stalls the input register; a character is still taken
// while the result waits whenever the input register is free.
module whitespace_comment_skipper_core (
    input  logic                             clk,
    input  logic                             rst_n,
    wcs_char_if.sink                         chars,
    wcs_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [wcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    wcs_pkg::cfg_t  cfg_reg, cfg_next;
    wcs_pkg::item_t item;
    logic           item_valid;
    logic           take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                wcs_pkg::CFG_SKIP_NEWLINES:    cfg_next.skip_newlines    = cfg_data[0];
                wcs_pkg::CFG_REQUIRE_NONEMPTY: cfg_next.require_nonempty = cfg_data[0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wcs_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .take  (take),
        .valid (item_valid),
        .item  (item)
    );

    wcs_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (item_valid),
        .item   (item),
        .cfg    (cfg_reg),
        .take   (take),
        .result (result)
    );

endmodule

>>> rtl/wcs_in_stage.sv
// Input register of the skipper: holds one character transfer.
// Depends on wcs_pkg and wcs_char_if.
module wcs_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    wcs_char_if.sink       chars,
    input  logic           take,
    output logic           valid,
    output wcs_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    wcs_pkg::item_t item_reg;
    logic           load;

    assign chars.ready = !valid_reg || take;
    assign load        = chars.valid && chars.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.ch           <= chars.ch;
            item_reg.first        <= chars.first;
            item_reg.end_of_input <= chars.end_of_input;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

>>> rtl/wcs_scan.sv
// Scan state machine and result register of the skipper.
// Depends on wcs_pkg and wcs_result_if.
module wcs_scan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    input  wcs_pkg::item_t item,
    input  wcs_pkg::cfg_t  cfg,
    output logic           take,
    wcs_result_if.source   result
);

    wcs_pkg::phase_t              phase_reg, phase_next;
    logic [wcs_pkg::NEST_W-1:0]   depth_reg, depth_next;
    logic [wcs_pkg::LEN_W-1:0]    consumed_reg, consumed_next;
    logic                         out_valid_reg, out_valid_next;
    logic [wcs_pkg::LEN_W-1:0]    out_len_reg, out_len_next;
    wcs_pkg::status_t             out_status_reg, out_status_next;

    wcs_pkg::phase_t              ph;
    logic [wcs_pkg::NEST_W-1:0]   dep;
    logic [wcs_pkg::LEN_W-1:0]    cons;
    logic [wcs_pkg::LEN_W:0]      sum;
    logic [1:0]                   add;
    logic                         fin;
    wcs_pkg::status_t             st;
    wcs_pkg::phase_t              nph;
    logic [wcs_pkg::NEST_W-1:0]   ndep;
    logic [wcs_pkg::NEST_W-1:0]   dep_dec;

    logic                         is_blank, is_lf, is_cr, is_slash, is_bsl, is_star;
    logic                         tc_end;
    logic [1:0]                   tc_add;
    wcs_pkg::phase_t              tc_ph;

    assign take = valid && (!out_valid_reg || result.ready);

    assign is_cr    = item.ch == wcs_pkg::CH_CR;
    assign is_lf    = item.ch == wcs_pkg::CH_LF;
    assign is_slash = item.ch == wcs_pkg::CH_SLASH;
    assign is_bsl   = item.ch == wcs_pkg::CH_BSL;
    assign is_star  = item.ch == wcs_pkg::CH_STAR;
    assign is_blank = item.ch == wcs_pkg::CH_SPACE || item.ch == wcs_pkg::CH_TAB
                   || is_cr || item.ch == wcs_pkg::CH_IDSP;

    // top-level character handling, shared by several phases
    always_comb
    begin
        tc_end = 1'b0;
        tc_add = 2'd0;
        tc_ph  = wcs_pkg::PH_TOP;
        if (is_blank)
        begin
            tc_add = 2'd1;
        end
        else if (is_lf)
        begin
            if (cfg.skip_newlines)
            begin
                tc_add = 2'd1;
            end
            else
            begin
                tc_end = 1'b1;
            end
        end
        else if (is_slash)
        begin
            tc_ph = wcs_pkg::PH_SLASH;
        end
        else if (is_bsl)
        begin
            tc_ph = wcs_pkg::PH_BSL;
        end
        else
        begin
            tc_end = 1'b1;
        end
    end

    always_comb
    begin
        ph      = item.first ? wcs_pkg::PH_TOP : phase_reg;
        dep     = item.first ? '0 : depth_reg;
        cons    = item.first ? '0 : consumed_reg;
        dep_dec = (dep != '0) ? dep - 1'b1 : dep;
        add     = 2'd0;
        fin     = 1'b0;
        st      = wcs_pkg::ST_OK;
        nph     = ph;
        ndep    = dep;

        if (ph == wcs_pkg::PH_IDLE)
        begin
            nph = wcs_pkg::PH_IDLE;
        end
        else if (item.end_of_input)
        begin
            fin = 1'b1;
            if (ph == wcs_pkg::PH_BLK || ph == wcs_pkg::PH_BLK_SLASH
                || ph == wcs_pkg::PH_BLK_STAR)
            begin
                st = wcs_pkg::ST_UNCLOSED;
            end
        end
        else
        begin
            unique case (ph)
                wcs_pkg::PH_TOP:
                begin
                    fin = tc_end;
                    add = tc_add;
                    nph = tc_ph;
                end
                wcs_pkg::PH_SLASH:
                begin
                    if (is_slash)
                    begin
                        add = 2'd2;
                        nph = wcs_pkg::PH_LINE;
                    end
                    else if (is_star)
                    begin
                        add  = 2'd2;
                        ndep = wcs_pkg::NEST_W'(1);
                        nph  = wcs_pkg::PH_BLK;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                wcs_pkg::PH_BSL:
                begin
                    if (is_cr)
                    begin
                        add = 2'd2;
                        nph = wcs_pkg::PH_BSCR;
                    end
                    else if (is_lf)
                    begin
                        add = 2'd2;
                        nph = wcs_pkg::PH_TOP;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                wcs_pkg::PH_BSCR:
                begin
                    if (is_lf)
                    begin
                        add = 2'd1;
                        nph = wcs_pkg::PH_TOP;
                    end
                    else
                    begin
                        fin = tc_end;
                        add = tc_add;
                        nph = tc_ph;
                    end
                end
                wcs_pkg::PH_LINE:
                begin
                    if (is_cr || is_lf)
                    begin
                        fin = tc_end;
                        add = tc_add;
                        nph = tc_ph;
                    end
                    else
                    begin
                        add = 2'd1;
                    end
                end
                wcs_pkg::PH_BLK:
                begin
                    add = 2'd1;
                    if (is_slash)
                    begin
                        nph = wcs_pkg::PH_BLK_SLASH;
                    end
                    else if (is_star)
                    begin
                        nph = wcs_pkg::PH_BLK_STAR;
                    end
                end
                wcs_pkg::PH_BLK_SLASH:
                begin
                    if (is_star)
                    begin
                        if (dep >= wcs_pkg::NEST_LIMIT)
                        begin
                            fin = 1'b1;
                            st  = wcs_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            add  = 2'd1;
                            ndep = dep + 1'b1;
                            nph  = wcs_pkg::PH_BLK;
                        end
                    end
                    else
                    begin
                        add = 2'd1;
                        if (!is_slash)
                        begin
                            nph = wcs_pkg::PH_BLK;
                        end
                    end
                end
                wcs_pkg::PH_BLK_STAR:
                begin
                    add = 2'd1;
                    if (is_slash)
                    begin
                        ndep = dep_dec;
                        nph  = (dep_dec == '0) ? wcs_pkg::PH_TOP : wcs_pkg::PH_BLK;
                    end
                    else if (!is_star)
                    begin
                        nph = wcs_pkg::PH_BLK;
                    end
                end
                default:
                begin
                    nph = wcs_pkg::PH_IDLE;
                end
            endcase
        end

        sum = {1'b0, cons} + {{(wcs_pkg::LEN_W-1){1'b0}}, add};

        phase_next    = phase_reg;
        depth_next    = depth_reg;
        consumed_next = consumed_reg;
        if (take)
        begin
            if (fin)
            begin
                phase_next = wcs_pkg::PH_IDLE;
                depth_next = '0;
            end
            else
            begin
                phase_next = nph;
                depth_next = ndep;
            end
            consumed_next = (sum > {1'b0, wcs_pkg::LEN_LIMIT}) ? wcs_pkg::LEN_LIMIT
                                                                : sum[wcs_pkg::LEN_W-1:0];
        end

        out_len_next    = out_len_reg;
        out_status_next = out_status_reg;
        if (take && fin)
        begin
            if (st == wcs_pkg::ST_OK)
            begin
                if (cfg.require_nonempty && cons == '0)
                begin
                    out_len_next    = '0;
                    out_status_next = wcs_pkg::ST_EMPTY;
                end
                else
                begin
                    out_len_next    = cons;
                    out_status_next = wcs_pkg::ST_OK;
                end
            end
            else
            begin
                out_len_next    = '0;
                out_status_next = st;
            end
        end

        if (take)
        begin
            out_valid_next = fin;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= wcs_pkg::PH_IDLE;
            depth_reg     <= '0;
            consumed_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            depth_reg     <= depth_next;
            consumed_reg  <= consumed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_len_reg    <= out_len_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.run_length = out_len_reg;
    assign result.status     = out_status_reg;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for whitespace_comment_skipper_core: directed table, random scans, checks.
// Depends on wcs_pkg, wcs_char_if and wcs_result_if from the rtl folder.
module tb;

    localparam int CYCLE_LIMIT   = 60000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_CAP       = int'(wcs_pkg::LEN_LIMIT);

    typedef struct packed {
        logic [wcs_pkg::LEN_W-1:0] run_length;
        wcs_pkg::status_t          status;
    } run_t;

    typedef struct {
        wcs_pkg::item_t it;
        bit             pinned;
        run_t           want;
    } table_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [wcs_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [wcs_pkg::CFG_DATA_W-1:0] cfg_data;

    wcs_char_if   char_bus ();
    wcs_result_if result_bus ();

    whitespace_comment_skipper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (char_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wcs_pkg::phase_t scan_phase;
    int              scan_depth;
    int              scan_len;
    bit              opt_skip_nl;
    bit              opt_need_text;

    run_t           awaited_runs[$];
    run_t           oldest_run;
    run_t           no_pin = '0;
    wcs_pkg::item_t scan_chars[$];
    table_row_t     stim_table[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int snd_idle_pct   = 0;
    int rcv_idle_pct   = 0;
    int holds_asked    = 0;
    int holds_served   = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(string what);
        if (mismatch_count < 50)
            $display("[cycle %0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic bit is_blank(logic [wcs_pkg::CH_W-1:0] c);
        return c == wcs_pkg::CH_SPACE || c == wcs_pkg::CH_TAB || c == wcs_pkg::CH_CR
            || c == wcs_pkg::CH_IDSP;
    endfunction

    function automatic void grow_run(int n);
        scan_len = (scan_len + n > RUN_CAP) ? RUN_CAP : scan_len + n;
    endfunction

    function automatic run_t close_scan(wcs_pkg::status_t st);
        run_t r;
        r = '0;
        r.status = st;
        if (st == wcs_pkg::ST_OK)
        begin
            r.run_length = wcs_pkg::LEN_W'(scan_len);
            if (opt_need_text && scan_len == 0)
                r.status = wcs_pkg::ST_EMPTY;
        end
        scan_phase = wcs_pkg::PH_IDLE;
        scan_depth = 0;
        return r;
    endfunction

    // returns 1 when the run ends before c
    function automatic bit ends_at_top(logic [wcs_pkg::CH_W-1:0] c);
        scan_phase = wcs_pkg::PH_TOP;
        if (is_blank(c))
        begin
            grow_run(1);
            return 1'b0;
        end
        if (c == wcs_pkg::CH_LF)
        begin
            if (!opt_skip_nl)
                return 1'b1;
            grow_run(1);
            return 1'b0;
        end
        if (c == wcs_pkg::CH_SLASH)
        begin
            scan_phase = wcs_pkg::PH_SLASH;
            return 1'b0;
        end
        if (c == wcs_pkg::CH_BSL)
        begin
            scan_phase = wcs_pkg::PH_BSL;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit advance_scan(wcs_pkg::item_t it, output run_t r);
        logic [wcs_pkg::CH_W-1:0] c;
        bit                       done;
        c = it.ch;
        done = 1'b0;
        r = '0;
        if (it.first)
        begin
            scan_phase = wcs_pkg::PH_TOP;
            scan_depth = 0;
            scan_len = 0;
        end
        if (scan_phase == wcs_pkg::PH_IDLE)
            return 1'b0;
        if (it.end_of_input)
        begin
            if (scan_phase == wcs_pkg::PH_BLK || scan_phase == wcs_pkg::PH_BLK_SLASH
                || scan_phase == wcs_pkg::PH_BLK_STAR)
                r = close_scan(wcs_pkg::ST_UNCLOSED);
            else
                r = close_scan(wcs_pkg::ST_OK);
            return 1'b1;
        end
        case (scan_phase)
            wcs_pkg::PH_TOP: done = ends_at_top(c);
            wcs_pkg::PH_SLASH:
                if (c == wcs_pkg::CH_SLASH)
                begin
                    grow_run(2);
                    scan_phase = wcs_pkg::PH_LINE;
                end
                else if (c == wcs_pkg::CH_STAR)
                begin
                    grow_run(2);
                    scan_depth = 1;
                    scan_phase = wcs_pkg::PH_BLK;
                end
                else
                    done = 1'b1;
            wcs_pkg::PH_BSL:
                if (c == wcs_pkg::CH_CR)
                begin
                    grow_run(2);
                    scan_phase = wcs_pkg::PH_BSCR;
                end
                else if (c == wcs_pkg::CH_LF)
                begin
                    grow_run(2);
                    scan_phase = wcs_pkg::PH_TOP;
                end
                else
                    done = 1'b1;
            wcs_pkg::PH_BSCR:
                if (c == wcs_pkg::CH_LF)
                begin
                    grow_run(1);
                    scan_phase = wcs_pkg::PH_TOP;
                end
                else
                    done = ends_at_top(c);
            wcs_pkg::PH_LINE:
                if (c == wcs_pkg::CH_CR || c == wcs_pkg::CH_LF)
                    done = ends_at_top(c);
                else
                    grow_run(1);
            wcs_pkg::PH_BLK:
            begin
                grow_run(1);
                if (c == wcs_pkg::CH_SLASH)
                    scan_phase = wcs_pkg::PH_BLK_SLASH;
                else if (c == wcs_pkg::CH_STAR)
                    scan_phase = wcs_pkg::PH_BLK_STAR;
            end
            wcs_pkg::PH_BLK_SLASH:
                if (c == wcs_pkg::CH_STAR)
                begin
                    if (scan_depth >= int'(wcs_pkg::MAX_NEST))
                    begin
                        r = close_scan(wcs_pkg::ST_OVERFLOW);
                        return 1'b1;
                    end
                    grow_run(1);
                    scan_depth++;
                    scan_phase = wcs_pkg::PH_BLK;
                end
                else
                begin
                    grow_run(1);
                    if (c != wcs_pkg::CH_SLASH)
                        scan_phase = wcs_pkg::PH_BLK;
                end
            wcs_pkg::PH_BLK_STAR:
            begin
                grow_run(1);
                if (c == wcs_pkg::CH_SLASH)
                begin
                    if (scan_depth > 0)
                        scan_depth--;
                    scan_phase = (scan_depth == 0) ? wcs_pkg::PH_TOP : wcs_pkg::PH_BLK;
                end
                else if (c != wcs_pkg::CH_STAR)
                    scan_phase = wcs_pkg::PH_BLK;
            end
            default: ;
        endcase
        if (done)
        begin
            r = close_scan(wcs_pkg::ST_OK);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (awaited_runs.size() == 0)
                report_mismatch($sformatf("unexpected result %h/%0d",
                                          result_bus.run_length, result_bus.status));
            else
            begin
                oldest_run = awaited_runs.pop_front();
                if (result_bus.run_length !== oldest_run.run_length)
                    report_mismatch($sformatf("run_length got %h want %h",
                                              result_bus.run_length, oldest_run.run_length));
                if (result_bus.status !== oldest_run.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result_bus.status, oldest_run.status));
            end
        end
    end

    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served = holds_asked;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("** whitespace_comment_skipper_core: FAILED **");
        $finish;
    end

    task automatic offer(wcs_pkg::item_t it, bit pinned, run_t want);
        run_t r;
        bit   emits;
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.ch           <= it.ch;
        char_bus.first        <= it.first;
        char_bus.end_of_input <= it.end_of_input;
        @(posedge clk);
        while (!char_bus.ready) @(posedge clk);
        emits = advance_scan(it, r);
        if (pinned)
        begin
            if (!emits || r != want)
                report_mismatch($sformatf("table row %h predicted as %h", it, r));
            awaited_runs.push_back(want);
        end
        else if (emits)
            awaited_runs.push_back(r);
    endtask

    task automatic settle();
        char_bus.valid <= 1'b0;
        while (awaited_runs.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_options(bit skip_nl, bit need_text);
        cfg_we    <= 1'b1;
        cfg_index <= wcs_pkg::CFG_SKIP_NEWLINES;
        cfg_data  <= skip_nl;
        @(posedge clk);
        cfg_index <= wcs_pkg::CFG_REQUIRE_NONEMPTY;
        cfg_data  <= need_text;
        @(posedge clk);
        cfg_we <= 1'b0;
        opt_skip_nl   = skip_nl;
        opt_need_text = need_text;
    endtask

    function automatic void add_row(logic [wcs_pkg::CH_W-1:0] c, bit f, bit e,
                                    bit pin, int len, wcs_pkg::status_t st);
        table_row_t row;
        row.it = {c, f, e};
        row.pinned = pin;
        row.want.run_length = wcs_pkg::LEN_W'(len);
        row.want.status = st;
        stim_table.push_back(row);
    endfunction

    function automatic void add_char(logic [wcs_pkg::CH_W-1:0] c);
        scan_chars.push_back({c, 1'b0, 1'b0});
    endfunction

    function automatic void add_eoi();
        scan_chars.push_back({16'($urandom), 1'b0, 1'b1});
    endfunction

    function automatic logic [wcs_pkg::CH_W-1:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return wcs_pkg::CH_SPACE;
            1: return wcs_pkg::CH_TAB;
            2: return wcs_pkg::CH_CR;
            default: return wcs_pkg::CH_IDSP;
        endcase
    endfunction

    function automatic logic [wcs_pkg::CH_W-1:0] pick_filler();
        case ($urandom_range(0, 7))
            0: return wcs_pkg::CH_STAR;
            1: return wcs_pkg::CH_SLASH;
            2: return wcs_pkg::CH_CR;
            3: return wcs_pkg::CH_LF;
            4: return wcs_pkg::CH_SPACE;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void add_block(bit closed);
        int open;
        open = 1;
        add_char(wcs_pkg::CH_SLASH);
        add_char(wcs_pkg::CH_STAR);
        repeat ($urandom_range(0, 8))
        begin
            case ($urandom_range(0, 9))
                0:
                    if (open < 4)
                    begin
                        add_char(wcs_pkg::CH_SLASH);
                        add_char(wcs_pkg::CH_STAR);
                        open++;
                    end
                1:
                    if (open > 1)
                    begin
                        add_char(wcs_pkg::CH_STAR);
                        add_char(wcs_pkg::CH_SLASH);
                        open--;
                    end
                default: add_char(pick_filler());
            endcase
        end
        while (closed && open > 0)
        begin
            add_char(wcs_pkg::CH_STAR);
            add_char(wcs_pkg::CH_SLASH);
            open--;
        end
    endfunction

    function automatic void build_scan();
        scan_chars.delete();
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_char(pick_blank());
                3: add_char(wcs_pkg::CH_LF);
                4:
                begin
                    add_char(wcs_pkg::CH_CR);
                    add_char(wcs_pkg::CH_LF);
                end
                5:
                begin
                    add_char(wcs_pkg::CH_BSL);
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            add_char(wcs_pkg::CH_CR);
                            add_char(wcs_pkg::CH_LF);
                        end
                        1: add_char(wcs_pkg::CH_CR);
                        default: add_char(wcs_pkg::CH_LF);
                    endcase
                end
                6, 7:
                begin
                    add_char(wcs_pkg::CH_SLASH);
                    add_char(wcs_pkg::CH_SLASH);
                    repeat ($urandom_range(0, 5)) add_char(pick_filler());
                    add_char($urandom_range(0, 1) ? wcs_pkg::CH_CR : wcs_pkg::CH_LF);
                end
                default: add_block(1'b1);
            endcase
        end
        case ($urandom_range(0, 7))
            0: add_eoi();
            1, 2: add_char(16'($urandom));
            3:
            begin
                add_char(wcs_pkg::CH_SLASH);
                add_char(16'($urandom));
            end
            4:
            begin
                add_char(wcs_pkg::CH_BSL);
                add_char(16'($urandom));
            end
            5:
            begin
                add_block(1'b0);
                add_eoi();
            end
            6: ;
            default:
            begin
                add_char($urandom_range(0, 1) ? wcs_pkg::CH_SLASH : wcs_pkg::CH_BSL);
                add_eoi();
            end
        endcase
    endfunction

    task automatic send_scan();
        wcs_pkg::item_t it;
        if (scan_chars.size() == 0)
            add_eoi();
        foreach (scan_chars[i])
        begin
            it = scan_chars[i];
            if (i == 0)
                it.first = 1'b1;
            offer(it, 1'b0, no_pin);
        end
    endtask

    task automatic run_random(int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                begin
                    offer(wcs_pkg::item_t'(18'($urandom)), 1'b0, no_pin);
                    sent++;
                end
            build_scan();
            send_scan();
            sent += scan_chars.size();
        end
        // close any open scan so the next configuration starts from idle
        offer({16'($urandom), 1'b0, 1'b1}, 1'b0, no_pin);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        char_bus.valid        = 1'b0;
        char_bus.ch           = '0;
        char_bus.first        = 1'b0;
        char_bus.end_of_input = 1'b0;
        scan_phase            = wcs_pkg::PH_IDLE;
        scan_depth            = 0;
        scan_len              = 0;
        opt_skip_nl           = 1'b0;
        opt_need_text         = 1'b0;
        snd_idle_pct          = 11;
        rcv_idle_pct          = 70;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_options(1'b0, 1'b1);
        add_row(16'hFFFF,          1'b0, 1'b1, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'h0000,          1'b1, 1'b1, 1'b1, 0, wcs_pkg::ST_EMPTY);
        add_row(wcs_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_TAB,   1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_IDSP,  1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_CR,    1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'h0041,          1'b0, 1'b0, 1'b1, 4, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'hFFFF,          1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_LF,    1'b0, 1'b0, 1'b1, 3, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_BSL,   1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_CR,    1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_LF,    1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_STAR,  1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_STAR,  1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_STAR,  1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SLASH, 1'b0, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'hFFFF,          1'b0, 1'b1, 1'b1, 0, wcs_pkg::ST_UNCLOSED);
        add_row(wcs_pkg::CH_BSL,   1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'h0078,          1'b0, 1'b0, 1'b1, 0, wcs_pkg::ST_EMPTY);
        add_row(wcs_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SPACE, 1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'h0000,          1'b0, 1'b1, 1'b1, 1, wcs_pkg::ST_OK);
        add_row(wcs_pkg::CH_SLASH, 1'b1, 1'b0, 1'b0, 0, wcs_pkg::ST_OK);
        add_row(16'h0000,          1'b0, 1'b1, 1'b1, 0, wcs_pkg::ST_EMPTY);
        foreach (stim_table[i])
            offer(stim_table[i].it, stim_table[i].pinned, stim_table[i].want);
        settle();

        set_options(1'b1, 1'b0);
        run_random(300);
        settle();

        snd_idle_pct = 70;
        rcv_idle_pct = 11;
        set_options(1'b0, 1'b0);
        run_random(300);
        settle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_options(1'b1, 1'b1);
        holds_asked++;
        run_random(280);

        scan_chars.delete();
        repeat (wcs_pkg::MAX_NEST + 1)
        begin
            add_char(wcs_pkg::CH_SLASH);
            add_char(wcs_pkg::CH_STAR);
        end
        send_scan();
        settle();

        if (mismatch_count == 0 && awaited_runs.size() == 0)
            $display("** whitespace_comment_skipper_core: PASSED **");
        else
            $display("** whitespace_comment_skipper_core: FAILED **");
        $finish;
    end

endmodule
